@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the gradient RTL.
// Define ASSERT_OFF to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ rtl/plcg_pkg.sv @@
`timescale 1ns / 1ps

package plcg_pkg;

   // Widths fixed by the register map and the item fields.
   localparam int VALUE_WIDTH  = 16;
   localparam int COUNT_BITS   = 3;
   localparam int NUM_STOPS    = 7;
   localparam int STOP_BITS    = 48;
   localparam int POS_LSB      = 32;
   localparam int CHAN_BITS    = 8;
   localparam int NUM_CHANS    = 4;
   localparam int FRAC_BITS    = 16;
   localparam int DIV_STEP     = 4;

   // Configuration port geometry: 64-bit registers at 8-byte spacing.
   localparam int DATA_BITS    = 64;
   localparam int ADDR_BITS    = 6;
   localparam int REG_LSB      = 3;
   localparam int REG_IDX_BITS = ADDR_BITS - REG_LSB;

   // Register indexes.
   localparam logic [REG_IDX_BITS-1:0] REG_STOP_COUNT = 3'd0;
   localparam logic [REG_IDX_BITS-1:0] REG_STOP_BASE  = 3'd1;

   // Lane numbers inside a packed color word.
   localparam int CH_RED   = 3;
   localparam int CH_GREEN = 2;
   localparam int CH_BLUE  = 1;
   localparam int CH_ALPHA = 0;

   // Reset values of the registers.
   localparam logic [COUNT_BITS-1:0] COUNT_RESET = 3'd2;
   localparam logic [STOP_BITS-1:0]  STOP0_RESET = 48'h0000_0000_00FF;
   localparam logic [STOP_BITS-1:0]  STOP1_RESET = 48'hFFFF_FFFF_FFFF;

   typedef logic [NUM_CHANS-1:0][CHAN_BITS-1:0] color_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0]                count;
      logic [NUM_STOPS-1:0][STOP_BITS-1:0]  stops;
   } cfg_type;

   // Colors of the two stops around the value, plus the error flag.
   typedef struct packed {
      color_type lo;
      color_type hi;
      logic      err;
   } pair_type;

   localparam cfg_type CFG_RESET = '{
      count: COUNT_RESET,
      stops: {{((NUM_STOPS - 2) * STOP_BITS){1'b0}}, STOP1_RESET, STOP0_RESET}
   };

endpackage

@@ rtl/plcg_csr.sv @@
`timescale 1ns / 1ps

module plcg_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [plcg_pkg::ADDR_BITS-1:0]     paddr,
   input  logic [plcg_pkg::DATA_BITS-1:0]     pwdata,
   output logic [plcg_pkg::DATA_BITS-1:0]     prdata,
   output logic                               pready,
   output plcg_pkg::cfg_type                  cfg
);
   import plcg_pkg::*;

   cfg_type                  cfg_ff;
   cfg_type                  cfg_in;
   logic [REG_IDX_BITS-1:0]  index;
   logic                     wr;

   // The port never inserts wait states.
   assign pready = 1'b1;
   assign index  = paddr[ADDR_BITS-1:REG_LSB];
   assign wr     = psel & penable & pwrite & pready;
   assign cfg    = cfg_ff;

   // Register write decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (index)
            REG_STOP_COUNT: begin
               cfg_in.count = pwdata[COUNT_BITS-1:0];
            end
            default: begin
               cfg_in.stops[index - REG_STOP_BASE] = pwdata[STOP_BITS-1:0];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read mux.
   always_comb begin
      case (index)
         REG_STOP_COUNT: begin
            prdata = DATA_BITS'(cfg_ff.count);
         end
         default: begin
            prdata = DATA_BITS'(cfg_ff.stops[index - REG_STOP_BASE]);
         end
      endcase
   end

endmodule

@@ rtl/plcg_locate.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module plcg_locate #(
   parameter int MAX_STOPS  = 7,
   parameter int VALUE_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  plcg_pkg::cfg_type                  cfg,
   input  logic                               in_valid,
   input  logic [plcg_pkg::VALUE_WIDTH-1:0]   in_value,
   output logic                               out_valid,
   output logic [VALUE_BITS-1:0]              out_num,
   output logic [VALUE_BITS-1:0]              out_den,
   output plcg_pkg::pair_type                 out_pair
);
   import plcg_pkg::*;

   localparam logic [COUNT_BITS-1:0] LIMIT = COUNT_BITS'(MAX_STOPS);

   logic [VALUE_BITS-1:0]  pos [NUM_STOPS];
   color_type              col [NUM_STOPS];
   logic [COUNT_BITS-1:0]  n;
   logic [COUNT_BITS-1:0]  last_idx;
   logic [VALUE_BITS-1:0]  last_pos;
   logic [VALUE_BITS-1:0]  v;

   // Stage 1: clamp and configuration check.
   logic                   s1_valid_ff, s1_valid_in;
   logic [VALUE_BITS-1:0]  s1_v_ff, s1_v_in;
   logic                   s1_err_ff, s1_err_in;

   // Stage 2: segment search.
   logic                   s2_valid_ff, s2_valid_in;
   logic [VALUE_BITS-1:0]  s2_v_ff, s2_v_in;
   logic                   s2_err_ff, s2_err_in;
   logic [COUNT_BITS-1:0]  s2_idx_ff, s2_idx_in;

   // Stage 3: segment operands.
   logic                   s3_valid_ff, s3_valid_in;
   logic [VALUE_BITS-1:0]  s3_num_ff, s3_num_in;
   logic [VALUE_BITS-1:0]  s3_den_ff, s3_den_in;
   pair_type               s3_pair_ff, s3_pair_in;

   // Unpack the stop registers.
   always_comb begin
      for (int k = 0; k < NUM_STOPS; k++) begin
         pos[k] = cfg.stops[k][POS_LSB +: VALUE_BITS];
         col[k] = cfg.stops[k][NUM_CHANS*CHAN_BITS-1:0];
      end
   end

   assign n        = cfg.count;
   assign last_idx = n - COUNT_BITS'(1);
   assign v        = in_value[VALUE_BITS-1:0];

   // Position of the final stop in use.
   always_comb begin
      last_pos = '0;
      for (int k = 0; k < MAX_STOPS; k++) begin
         if (COUNT_BITS'(k) == last_idx) begin
            last_pos = pos[k];
         end
      end
   end

   // Stage 1 next state: clamp the value and check the stop list.
   always_comb begin
      s1_valid_in = in_valid;
      s1_err_in   = (n < COUNT_BITS'(2)) || (n > LIMIT);
      for (int k = 0; k < MAX_STOPS - 1; k++) begin
         if ((COUNT_BITS'(k + 1) < n) && (pos[k] >= pos[k + 1])) begin
            s1_err_in = 1'b1;
         end
      end
      s1_v_in = v;
      if (s1_v_in < pos[0]) begin
         s1_v_in = pos[0];
      end
      if (s1_v_in > last_pos) begin
         s1_v_in = last_pos;
      end
   end

   // Stage 2 next state: last stop in use at or below the value.
   always_comb begin
      s2_valid_in = s1_valid_ff;
      s2_v_in     = s1_v_ff;
      s2_err_in   = s1_err_ff;
      s2_idx_in   = '0;
      for (int k = 1; k < MAX_STOPS; k++) begin
         if ((COUNT_BITS'(k) < n) && (pos[k] <= s1_v_ff)) begin
            s2_idx_in = COUNT_BITS'(k);
         end
      end
   end

   // Stage 3 next state: numerator, denominator and the two colors.
   // At the final stop the divider sees 0/1 and both colors are equal.
   always_comb begin
      logic [VALUE_BITS-1:0] lo_pos;
      logic [VALUE_BITS-1:0] hi_pos;
      color_type             lo_col;
      color_type             hi_col;
      logic                  at_last;

      lo_pos = '0;
      hi_pos = '0;
      lo_col = '0;
      hi_col = '0;
      for (int k = 0; k < MAX_STOPS; k++) begin
         if (COUNT_BITS'(k) == s2_idx_ff) begin
            lo_pos = pos[k];
            lo_col = col[k];
         end
         if ((k > 0) && (COUNT_BITS'(k) == s2_idx_ff + COUNT_BITS'(1))) begin
            hi_pos = pos[k];
            hi_col = col[k];
         end
      end
      at_last        = (s2_idx_ff == last_idx);
      s3_valid_in    = s2_valid_ff;
      s3_num_in      = at_last ? '0 : s2_v_ff - lo_pos;
      s3_den_in      = at_last ? VALUE_BITS'(1) : hi_pos - lo_pos;
      s3_pair_in.lo  = lo_col;
      s3_pair_in.hi  = at_last ? lo_col : hi_col;
      s3_pair_in.err = s2_err_ff;
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      s1_v_ff    <= s1_v_in;
      s1_err_ff  <= s1_err_in;
      s2_v_ff    <= s2_v_in;
      s2_err_ff  <= s2_err_in;
      s2_idx_ff  <= s2_idx_in;
      s3_num_ff  <= s3_num_in;
      s3_den_ff  <= s3_den_in;
      s3_pair_ff <= s3_pair_in;
   end

   assign out_valid = s3_valid_ff;
   assign out_num   = s3_num_ff;
   assign out_den   = s3_den_ff;
   assign out_pair  = s3_pair_ff;

   // An item in the search stage moves on to the operand stage.
   `ASSERT_NEXT(a_loc_advance, clock, reset, s2_valid_ff, s3_valid_ff)

endmodule

@@ rtl/plcg_div.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module plcg_div #(
   parameter int VALUE_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   input  logic [VALUE_BITS-1:0]              in_num,
   input  logic [VALUE_BITS-1:0]              in_den,
   input  plcg_pkg::pair_type                 in_pair,
   output logic                               out_valid,
   output logic [plcg_pkg::FRAC_BITS-1:0]     out_frac,
   output plcg_pkg::pair_type                 out_pair
);
   import plcg_pkg::*;

   localparam int STAGES = FRAC_BITS / DIV_STEP;

   logic                   valid_ff [STAGES];
   logic [VALUE_BITS-1:0]  rem_ff   [STAGES];
   logic [VALUE_BITS-1:0]  den_ff   [STAGES];
   logic [FRAC_BITS-1:0]   quo_ff   [STAGES];
   pair_type               pair_ff  [STAGES];

   // Restoring division of num * 2^16 by den, num below den. Each stage
   // retires DIV_STEP quotient bits and keeps the remainder below den.
   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      logic                   src_valid;
      logic [VALUE_BITS-1:0]  src_rem;
      logic [VALUE_BITS-1:0]  src_den;
      logic [FRAC_BITS-1:0]   src_quo;
      pair_type               src_pair;
      logic [VALUE_BITS-1:0]  rem_in;
      logic [FRAC_BITS-1:0]   quo_in;

      if (s == 0) begin : g_first
         assign src_valid = in_valid;
         assign src_rem   = in_num;
         assign src_den   = in_den;
         assign src_quo   = '0;
         assign src_pair  = in_pair;
      end else begin : g_next
         assign src_valid = valid_ff[s - 1];
         assign src_rem   = rem_ff[s - 1];
         assign src_den   = den_ff[s - 1];
         assign src_quo   = quo_ff[s - 1];
         assign src_pair  = pair_ff[s - 1];
      end

      // Shift, trial subtract, keep or restore.
      always_comb begin
         logic [VALUE_BITS:0]    trial;
         logic [VALUE_BITS-1:0]  rem;
         logic [FRAC_BITS-1:0]   quo;

         rem = src_rem;
         quo = src_quo;
         for (int b = 0; b < DIV_STEP; b++) begin
            trial = {rem, 1'b0};
            quo   = {quo[FRAC_BITS-2:0], 1'b0};
            if (trial >= {1'b0, src_den}) begin
               trial  = trial - {1'b0, src_den};
               quo[0] = 1'b1;
            end
            rem = trial[VALUE_BITS-1:0];
         end
         rem_in = rem;
         quo_in = quo;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else begin
            valid_ff[s] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[s]  <= rem_in;
         den_ff[s]  <= src_den;
         quo_ff[s]  <= quo_in;
         pair_ff[s] <= src_pair;
      end
   end

   assign out_valid = valid_ff[STAGES - 1];
   assign out_frac  = quo_ff[STAGES - 1];
   assign out_pair  = pair_ff[STAGES - 1];

   // No item is dropped between the last two divider stages.
   `ASSERT_NEXT(a_div_advance, clock, reset, valid_ff[STAGES - 2], valid_ff[STAGES - 1])

endmodule

@@ rtl/plcg_blend.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module plcg_blend (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   input  logic [plcg_pkg::FRAC_BITS-1:0]     in_frac,
   input  plcg_pkg::pair_type                 in_pair,
   output logic                               out_strobe,
   output logic [plcg_pkg::CHAN_BITS-1:0]     out_red,
   output logic [plcg_pkg::CHAN_BITS-1:0]     out_green,
   output logic [plcg_pkg::CHAN_BITS-1:0]     out_blue,
   output logic [plcg_pkg::CHAN_BITS-1:0]     out_alpha,
   output logic                               out_error
);
   import plcg_pkg::*;

   localparam int PROD_BITS = FRAC_BITS + CHAN_BITS + 2;
   localparam logic signed [PROD_BITS-1:0] ROUND = PROD_BITS'(1 << (FRAC_BITS - 1));

   // Multiply stage.
   logic                         mul_valid_ff, mul_valid_in;
   logic signed [PROD_BITS-1:0]  prod_ff [NUM_CHANS];
   logic signed [PROD_BITS-1:0]  prod_in [NUM_CHANS];
   color_type                    lo_ff;
   logic                         err_ff;

   // Output stage.
   logic                         strobe_ff, strobe_in;
   color_type                    col_ff, col_in;
   logic                         error_ff;

   // (1 - f) * lo + f * hi is lo + f * (hi - lo), one multiply per lane.
   always_comb begin
      logic signed [FRAC_BITS:0]  frac_s;
      logic signed [CHAN_BITS:0]  diff;

      frac_s       = $signed({1'b0, in_frac});
      mul_valid_in = in_valid;
      for (int ch = 0; ch < NUM_CHANS; ch++) begin
         diff        = $signed({1'b0, in_pair.hi[ch]}) - $signed({1'b0, in_pair.lo[ch]});
         prod_in[ch] = PROD_BITS'(frac_s) * PROD_BITS'(diff);
      end
   end

   // Add the low color, round to nearest and drop the fraction.
   always_comb begin
      logic signed [PROD_BITS-1:0] sum;

      strobe_in = mul_valid_ff;
      for (int ch = 0; ch < NUM_CHANS; ch++) begin
         sum        = $signed({2'b00, lo_ff[ch], {FRAC_BITS{1'b0}}}) + prod_ff[ch] + ROUND;
         col_in[ch] = err_ff ? '0 : sum[FRAC_BITS +: CHAN_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         strobe_ff    <= 1'b0;
      end else begin
         mul_valid_ff <= mul_valid_in;
         strobe_ff    <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int ch = 0; ch < NUM_CHANS; ch++) begin
         prod_ff[ch] <= prod_in[ch];
      end
      lo_ff    <= in_pair.lo;
      err_ff   <= in_pair.err;
      col_ff   <= col_in;
      error_ff <= err_ff;
   end

   assign out_strobe = strobe_ff;
   assign out_red    = col_ff[CH_RED];
   assign out_green  = col_ff[CH_GREEN];
   assign out_blue   = col_ff[CH_BLUE];
   assign out_alpha  = col_ff[CH_ALPHA];
   assign out_error  = error_ff;

   // A product in flight always turns into one result strobe.
   `ASSERT_NEXT(a_blend_strobe, clock, reset, mul_valid_ff, strobe_ff)
   // An empty multiply stage never shows a result.
   `ASSERT_NEXT(a_blend_quiet, clock, reset, !mul_valid_ff, !strobe_ff)
   // Error results carry a zero color.
   `ASSERT_IMPLY(a_blend_err_zero, clock, reset, strobe_ff && error_ff, col_ff == '0)

endmodule

@@ rtl/piecewise_linear_color_gradient.sv @@
`timescale 1ns / 1ps
// Piecewise-linear color gradient: maps a scalar to an RGBA color.
// Input channel: an item (req_value) is accepted at a clock edge with start
// high; busy is always low, so a new item can be taken every cycle.
// Result channel: rsp_strobe is high for one cycle with rsp_red, rsp_green,
// rsp_blue, rsp_alpha and rsp_error; the receiver cannot hold results off.
// Throughput: one item per cycle. The path is nine register stages: clamp
// and stop check, segment search, segment operands, four divider stages of
// four quotient bits each, the lane multipliers and the rounding stage.
// Configuration: a 64-bit APB port, register i at byte address 8*i
// (stop count, then seven stops). Write only while no item is in flight.
// Reset (synchronous, active high) empties the pipeline and loads the
// default gradient: two stops, opaque black at 0 to opaque white at 0xFFFF.
// Fewer than two stops, too many, or stops not strictly ascending give a
// result with rsp_error set and a zero color.
module piecewise_linear_color_gradient #(
   parameter int MAX_STOPS  = 7,
   parameter int VALUE_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [plcg_pkg::VALUE_WIDTH-1:0]   req_value,
   output logic                               rsp_strobe,
   output logic [plcg_pkg::CHAN_BITS-1:0]     rsp_red,
   output logic [plcg_pkg::CHAN_BITS-1:0]     rsp_green,
   output logic [plcg_pkg::CHAN_BITS-1:0]     rsp_blue,
   output logic [plcg_pkg::CHAN_BITS-1:0]     rsp_alpha,
   output logic                               rsp_error,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [plcg_pkg::ADDR_BITS-1:0]     paddr,
   input  logic [plcg_pkg::DATA_BITS-1:0]     pwdata,
   output logic [plcg_pkg::DATA_BITS-1:0]     prdata,
   output logic                               pready
);
   import plcg_pkg::*;

   cfg_type                cfg;
   logic                   accept;
   logic                   loc_valid;
   logic [VALUE_BITS-1:0]  loc_num;
   logic [VALUE_BITS-1:0]  loc_den;
   pair_type               loc_pair;
   logic                   div_valid;
   logic [FRAC_BITS-1:0]   div_frac;
   pair_type               div_pair;

   // The pipeline never stalls.
   assign busy   = 1'b0;
   assign accept = start & ~busy;

   plcg_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   plcg_locate #(
      .MAX_STOPS  (MAX_STOPS),
      .VALUE_BITS (VALUE_BITS)
   ) u_locate (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (accept),
      .in_value  (req_value),
      .out_valid (loc_valid),
      .out_num   (loc_num),
      .out_den   (loc_den),
      .out_pair  (loc_pair)
   );

   plcg_div #(
      .VALUE_BITS (VALUE_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (loc_valid),
      .in_num    (loc_num),
      .in_den    (loc_den),
      .in_pair   (loc_pair),
      .out_valid (div_valid),
      .out_frac  (div_frac),
      .out_pair  (div_pair)
   );

   plcg_blend u_blend (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (div_valid),
      .in_frac    (div_frac),
      .in_pair    (div_pair),
      .out_strobe (rsp_strobe),
      .out_red    (rsp_red),
      .out_green  (rsp_green),
      .out_blue   (rsp_blue),
      .out_alpha  (rsp_alpha),
      .out_error  (rsp_error)
   );

endmodule
